[rtl/mgsp_pkg.sv]
// shared types and constants for the maximal goal subset prune table
package mgsp_pkg;

  // fixed field widths
  localparam int MASK_W     = 32;
  localparam int COST_W     = 31;
  localparam int HV_W       = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_GOAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_LIMIT = 2'd2;

  // reset values and saturation bound
  localparam logic [COST_W-1:0] COST_LIMIT_RST = 31'h7FFF_FFFF;
  localparam logic [HV_W-1:0]   HV_MAX         = 32'h7FFF_FFFF;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN1,
    ST_DRAIN1,
    ST_SCAN2,
    ST_DRAIN2,
    ST_INSERT,
    ST_FINISH
  } st_t;

  // subset compare results for one table entry
  typedef struct packed {
    logic reach_in_e;
    logic sat_in_e;
    logic e_in_sat;
  } cmp_res_t;

endpackage

[rtl/mgsp_if.sv]
// valid/ready channel interfaces for search states and results
interface mgsp_in_if import mgsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] path_cost;
  logic [MASK_W-1:0] reachable_mask;
  logic [MASK_W-1:0] satisfied_mask;

  modport source (output valid, path_cost, reachable_mask, satisfied_mask, input ready);
  modport sink   (input valid, path_cost, reachable_mask, satisfied_mask, output ready);
endinterface

interface mgsp_out_if import mgsp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   prune_flag;
  logic signed [HV_W-1:0] heuristic_value;
  logic                   table_changed;
  logic                   table_overflow;

  modport source (output valid, prune_flag, heuristic_value, table_changed, table_overflow,
                  input ready);
  modport sink   (input valid, prune_flag, heuristic_value, table_changed, table_overflow,
                  output ready);
endinterface

[rtl/mgsp_ram.sv]
// generic single write port RAM with registered read
module mgsp_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mgsp_cmp.sv]
// shared subset compare unit, one table entry against the current state's masks
module mgsp_cmp import mgsp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         entry_valid,
  input  logic [W-1:0] entry_mask,
  input  logic [W-1:0] reach,
  input  logic [W-1:0] sat,
  output cmp_res_t     res
);

  // a is covered by b when no bit of a lies outside b
  always_comb begin
    res.reach_in_e = entry_valid && ((reach & ~entry_mask) == '0);
    res.sat_in_e   = entry_valid && ((sat & ~entry_mask) == '0);
    res.e_in_sat   = entry_valid && ((entry_mask & ~sat) == '0);
  end

endmodule

[rtl/maximal_goal_subset_prune_table_top.sv]
// Maximal goal subset prune table: one search state per transfer in, one verdict per transfer
// out. The entry table lives in a single RAM (valid bit plus mask) read through one shared
// subset compare unit. An item holds the block from its accept until its result is loaded,
// and no new item is accepted before then. The time goes on a first pass over all entries for
// the prune and cover checks, then a second pass that drops covered entries and finds the
// lowest free slot, then the insert write and the result load. The second pass runs only when
// every hard goal is satisfied and no entry already covers the satisfied mask; otherwise the
// item goes from the first pass straight to the result load. After reset a clearing pass over
// all entries runs before the first item is taken; configuration writes are taken throughout. A
// finished result waits in an output register while the next item is accepted; if that
// result is still not taken when the next one is ready, the sequencer holds in its last
// state until the output register frees.
module maximal_goal_subset_prune_table_top import mgsp_pkg::*; #(
  parameter int GOAL_BITS     = 32,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mgsp_in_if.sink               in_chan,
  mgsp_out_if.source            out_chan
);

  localparam int MaskW = (GOAL_BITS < MASK_W) ? GOAL_BITS : MASK_W;
  localparam int EntW  = MaskW + 1;
  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

  // configuration registers
  logic [MASK_W-1:0] hard_goal_r;
  logic              prune_en_r;
  logic [COST_W-1:0] cost_limit_r;

  // sequencer and item registers
  st_t             state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            rvld_r, rvld_nxt;
  logic [AW-1:0]   raddr_r, raddr_nxt;
  logic            pruned_r, pruned_nxt;
  logic            covered_r, covered_nxt;
  logic            free_found_r, free_found_nxt;
  logic [AW-1:0]   slot_r, slot_nxt;
  logic            chg_r, chg_nxt;
  logic            ovf_r, ovf_nxt;
  logic [COST_W-1:0] cost_r;
  logic [MaskW-1:0]  reach_r;
  logic [MaskW-1:0]  sat_r;
  logic              hard_sat_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_prune_r;
  logic [HV_W-1:0]   out_hv_r;
  logic              out_chg_r;
  logic              out_ovf_r;
  logic              out_load;

  // RAM and compare unit signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EntW-1:0]   ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EntW-1:0]   ram_rdata;
  cmp_res_t          cmp;

  logic              in_xfer;
  logic [MaskW-1:0]  hard_cut;
  logic [COST_W+1:0] hv_diff;
  logic [HV_W-1:0]   hv_sat;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign hard_cut = hard_goal_r[MaskW-1:0];

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_goal_r  <= '0;
      prune_en_r   <= 1'b1;
      cost_limit_r <= COST_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HARD_GOAL:  hard_goal_r  <= cfg_wdata[MASK_W-1:0];
        CFG_PRUNE_EN:   prune_en_r   <= cfg_wdata[0];
        CFG_COST_LIMIT: cost_limit_r <= cfg_wdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // entry table
  mgsp_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared subset compare
  mgsp_cmp #(
    .W (MaskW)
  ) u_cmp (
    .entry_valid (ram_rdata[MaskW]),
    .entry_mask  (ram_rdata[MaskW-1:0]),
    .reach       (reach_r),
    .sat         (sat_r),
    .res         (cmp)
  );

  // remaining cost plus one, saturated at the top
  assign hv_diff = {2'b00, cost_limit_r} - {2'b00, cost_r} + (COST_W+2)'(1);
  assign hv_sat  = (!hv_diff[COST_W+1] && hv_diff[COST_W]) ? HV_MAX : hv_diff[HV_W-1:0];

  // sequencer state and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      rvld_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      rvld_r       <= rvld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // item payload and scan flags
  always_ff @(posedge clk) begin
    raddr_r      <= raddr_nxt;
    pruned_r     <= pruned_nxt;
    covered_r    <= covered_nxt;
    free_found_r <= free_found_nxt;
    slot_r       <= slot_nxt;
    chg_r        <= chg_nxt;
    ovf_r        <= ovf_nxt;
    if (in_xfer) begin
      cost_r     <= in_chan.path_cost;
      reach_r    <= in_chan.reachable_mask[MaskW-1:0];
      sat_r      <= in_chan.satisfied_mask[MaskW-1:0];
      hard_sat_r <= ((hard_cut & ~in_chan.satisfied_mask[MaskW-1:0]) == '0);
    end
    if (out_load) begin
      out_prune_r <= pruned_r && prune_en_r;
      out_hv_r    <= (pruned_r && prune_en_r) ? hv_sat : '0;
      out_chg_r   <= chg_r;
      out_ovf_r   <= ovf_r;
    end
  end

  // next state, RAM control and scan evaluation
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rvld_nxt       = 1'b0;
    raddr_nxt      = idx_r;
    pruned_nxt     = pruned_r;
    covered_nxt    = covered_r;
    free_found_nxt = free_found_r;
    slot_nxt       = slot_r;
    chg_nxt        = chg_r;
    ovf_nxt        = ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = raddr_r;
    ram_wdata      = '0;
    ram_raddr      = idx_r;
    out_load       = 1'b0;

    // first pass: prune and cover checks against the table before update
    if ((state_r == ST_SCAN1 || state_r == ST_DRAIN1) && rvld_r) begin
      pruned_nxt  = pruned_r | cmp.reach_in_e;
      covered_nxt = covered_r | cmp.sat_in_e;
    end

    // second pass: drop covered entries, note the lowest free slot
    if ((state_r == ST_SCAN2 || state_r == ST_DRAIN2) && rvld_r) begin
      if (cmp.e_in_sat) begin
        ram_we    = 1'b1;
        ram_waddr = raddr_r;
        ram_wdata = '0;
      end
      if ((!ram_rdata[MaskW] || cmp.e_in_sat) && !free_found_r) begin
        free_found_nxt = 1'b1;
        slot_nxt       = raddr_r;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '0;
        if (idx_r == LastIdx) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt        = '0;
          pruned_nxt     = ((hard_cut & ~in_chan.reachable_mask[MaskW-1:0]) != '0);
          covered_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          chg_nxt        = 1'b0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_SCAN1;
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        rvld_nxt  = 1'b1;
        raddr_nxt = idx_r;
        if (idx_r == LastIdx) begin
          idx_nxt   = '0;
          state_nxt = (state_r == ST_SCAN1) ? ST_DRAIN1 : ST_DRAIN2;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DRAIN1: begin
        state_nxt = (hard_sat_r && !covered_nxt) ? ST_SCAN2 : ST_FINISH;
      end
      ST_DRAIN2: begin
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        if (free_found_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = {1'b1, sat_r};
          chg_nxt   = 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register handshake
    out_valid_nxt = (out_valid_r && !out_chan.ready) || out_load;
  end

  // channel ports
  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.prune_flag      = out_prune_r;
  assign out_chan.heuristic_value = out_hv_r;
  assign out_chan.table_changed   = out_chg_r;
  assign out_chan.table_overflow  = out_ovf_r;

  // a result never both inserts and overflows
  a_chg_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_chg_r && out_ovf_r))
    else $error("result reports both insert and overflow");

  // heuristic is zero unless the state was pruned
  a_hv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_prune_r) |-> (out_hv_r == '0))
    else $error("nonzero heuristic on unpruned state");

  // drop writes never hit the entry being read in the same cycle
  a_drop_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN2 && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("drop write collides with scan read");

  // an accepted item starts the first pass at entry zero
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SCAN1 && idx_r == '0))
    else $error("accepted item did not start first pass");

  // an insert only follows a second pass
  a_insert_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> ($past(state_r) == ST_DRAIN2))
    else $error("insert without second pass");

endmodule

[bench/maximal_goal_subset_prune_table_top_tb.sv]
// self-checking testbench for the maximal goal subset prune table top level
module maximal_goal_subset_prune_table_top_tb import mgsp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ENTRIES      = 64;
  localparam int     ITEM_CYCLES  = 2*ENTRIES+5;
  localparam int     RANDOM_ITEMS = 1950;
  localparam int     PHASES       = 8;
  localparam longint CYCLE_LIMIT  = 6_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [MASK_W-1:0]    ALL_GOALS  = '1;

  typedef struct packed {
    logic                   prune_flag;
    logic signed [HV_W-1:0] heuristic_value;
    logic                   table_changed;
    logic                   table_overflow;
  } verdict_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [MASK_W-1:0] reach;
    logic [MASK_W-1:0] sat;
    logic              typed;
    verdict_t          want;
  } probe_row_t;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_CHOPPY,
    RX_HOLD
  } rx_mode_t;

  localparam verdict_t NO_TYPED = '0;
  localparam int PROBE_COUNT = 16;

  // directed rows: typed verdicts where they follow from an empty table and the rows before
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    // empty table, zero masks: zero inserted
    '{31'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
    // zero reach covered, heuristic saturates, zero sat already held
    '{31'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, HV_MAX, 1'b0, 1'b0}},
    // full path cost leaves one, zero entry dropped for bit 0
    '{31'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b1, 32'd1, 1'b1, 1'b0}},
    // all goals reachable, top bit inserted beside bit 0
    '{31'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
    // one mask covering both entries replaces them
    '{31'h0000_0005, 32'h8000_0001, 32'h8000_0001, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
    '{31'h7FFF_FFFE, 32'h0000_0001, 32'h0000_0001, 1'b1, '{1'b1, 32'd2, 1'b0, 1'b0}},
    // from here on the predictor decides
    '{31'h0001_2345, 32'h5555_5555, 32'h5555_5555, 1'b0, NO_TYPED},
    '{31'h0000_0000, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, NO_TYPED},
    '{31'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, NO_TYPED},
    '{31'h4000_0000, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, NO_TYPED},
    '{31'h0000_0001, 32'h0F0F_0F0F, 32'h5555_0000, 1'b0, NO_TYPED},
    '{31'h0000_0002, 32'h5555_5555, 32'hD555_5555, 1'b0, NO_TYPED},
    '{31'h3FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_TYPED},
    '{31'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0002, 1'b0, NO_TYPED},
    '{31'h2AAA_AAAA, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_TYPED},
    '{31'h5555_5555, 32'h6AAA_AAAA, 32'h3C3C_3C3C, 1'b0, NO_TYPED}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mgsp_in_if  state_if ();
  mgsp_out_if verdict_if ();

  maximal_goal_subset_prune_table_top #(
    .GOAL_BITS    (32),
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (state_if),
    .out_chan (verdict_if)
  );

  // predictor copy of the goal set and registers
  bit                goal_valid [ENTRIES];
  logic [MASK_W-1:0] goal_mask  [ENTRIES];
  logic [MASK_W-1:0] cfg_hard   = '0;
  logic              cfg_prune  = 1'b1;
  logic [COST_W-1:0] cfg_limit  = COST_LIMIT_RST;

  verdict_t expected_verdicts [$];
  int       err_count     = 0;
  int       verdicts_seen = 0;
  longint   cycle_count   = 0;
  int       burst_left    = 0;

  // stimulus knobs of the current phase
  int ph_wlo      = 4;
  int ph_whi      = 16;
  bit ph_fill     = 1'b0;
  bit ph_sat_hard = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // verdict for one accepted search state, updating the goal set as the block does
  task automatic judge_state(input logic [COST_W-1:0] cost, input logic [MASK_W-1:0] reach,
                             input logic [MASK_W-1:0] sat, output verdict_t v);
    bit     pruned;
    bit     covered;
    int     slot;
    longint hv;
    v = '0;
    // prune check runs against the goal set before any update
    pruned = ((cfg_hard & reach) != cfg_hard);
    if (!pruned) begin
      for (int i = 0; i < ENTRIES; i++)
        if (goal_valid[i] && ((reach & ~goal_mask[i]) == '0)) pruned = 1'b1;
    end
    // insert only when every hard goal holds and nothing covers the mask
    if ((cfg_hard & sat) == cfg_hard) begin
      covered = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
        if (goal_valid[i] && ((sat & ~goal_mask[i]) == '0)) covered = 1'b1;
      if (!covered) begin
        for (int i = 0; i < ENTRIES; i++)
          if (goal_valid[i] && ((goal_mask[i] & ~sat) == '0)) goal_valid[i] = 1'b0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (!goal_valid[i] && slot < 0) slot = i;
        if (slot >= 0) begin
          goal_valid[slot] = 1'b1;
          goal_mask[slot]  = sat;
          v.table_changed  = 1'b1;
        end else begin
          v.table_overflow = 1'b1;
        end
      end
    end
    // remaining cost plus one, saturated at the top
    if (pruned && cfg_prune) begin
      hv = longint'(cfg_limit) - longint'(cost) + 1;
      if (hv > longint'(HV_MAX)) hv = longint'(HV_MAX);
      v.prune_flag      = 1'b1;
      v.heuristic_value = hv[HV_W-1:0];
    end
  endtask

  function automatic logic [MASK_W-1:0] weighted_mask(input int w);
    logic [MASK_W-1:0] m;
    m = '0;
    while ($countones(m) < w) m[$urandom_range(MASK_W-1)] = 1'b1;
    return m;
  endfunction

  // random valid goal set entry, 0 when the set is empty
  function automatic bit stored_goal_set(output logic [MASK_W-1:0] m);
    int count;
    int pick;
    count = 0;
    m = '0;
    for (int i = 0; i < ENTRIES; i++) if (goal_valid[i]) count++;
    if (count == 0) return 1'b0;
    pick = $urandom_range(count-1);
    for (int i = 0; i < ENTRIES; i++) begin
      if (goal_valid[i]) begin
        if (pick == 0) m = goal_mask[i];
        pick--;
      end
    end
    return 1'b1;
  endfunction

  // one random search state shaped by the goal set and the phase knobs
  task automatic pick_state(output logic [COST_W-1:0] cost, output logic [MASK_W-1:0] reach,
                            output logic [MASK_W-1:0] sat);
    int                kind;
    bit                have;
    logic [MASK_W-1:0] base;
    logic [31:0]       raw;
    have  = stored_goal_set(base);
    kind  = $urandom_range(99);
    reach = weighted_mask($urandom_range(ph_wlo, ph_whi));
    sat   = weighted_mask($urandom_range(ph_wlo, ph_whi));
    if (ph_fill && kind < 70) begin
      // equal weight masks form an antichain and fill the set
      reach = weighted_mask(16);
      sat   = weighted_mask(16);
    end else if (kind < 30) begin
      // fresh masks as drawn
    end else if (kind < 50 && have && $countones(base) < 24) begin
      sat = base | weighted_mask($urandom_range(1, 3));
    end else if (kind < 65 && have) begin
      sat   = base & $urandom;
      reach = base & $urandom;
    end else if (kind < 80 && have) begin
      reach = base & ~($urandom & $urandom);
    end else if (kind < 90) begin
      reach = $urandom;
      sat   = $urandom;
    end
    // hard goals mostly met, the last tenth misses some on purpose
    if (kind < 90) begin
      if ($urandom_range(9) < 8) reach = reach | cfg_hard;
      if (ph_sat_hard && $urandom_range(9) < 8) sat = sat | cfg_hard;
    end else begin
      reach = reach & ~(cfg_hard & $urandom);
      sat   = sat & ~(cfg_hard & $urandom);
    end
    case ($urandom_range(7))
      0:       raw = '0;
      1:       raw = '1;
      2:       raw = {1'b0, cfg_limit} - $urandom_range(0, 40);
      3:       raw = {1'b0, cfg_limit} + $urandom_range(0, 40);
      default: raw = $urandom;
    endcase
    cost = raw[COST_W-1:0];
  endtask

  // offer one search state in bursts and gaps, predict it on transfer
  task automatic send_state(input logic [COST_W-1:0] cost, input logic [MASK_W-1:0] reach,
                            input logic [MASK_W-1:0] sat, input logic typed,
                            input verdict_t want);
    verdict_t v;
    int       gap;
    if (burst_left == 0) begin
      state_if.valid <= 1'b0;
      gap = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(1, 300);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 8);
    end
    state_if.valid          <= 1'b1;
    state_if.path_cost      <= cost;
    state_if.reachable_mask <= reach;
    state_if.satisfied_mask <= sat;
    do @(posedge clk); while (!state_if.ready);
    judge_state(cost, reach, sat, v);
    if (typed) v = want;
    expected_verdicts = {expected_verdicts, v};
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HARD_GOAL:  cfg_hard  = data[MASK_W-1:0];
      CFG_PRUNE_EN:   cfg_prune = data[0];
      CFG_COST_LIMIT: cfg_limit = data[COST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic settle();
    state_if.valid <= 1'b0;
    wait (expected_verdicts.size() == 0);
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at verdict %0d: %s got %0h want %0h", verdicts_seen, what, got, want);
    err_count++;
  endtask

  // result side stalls on a segment pattern of its own
  rx_mode_t rx_mode = RX_FLOW;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(5))
        0, 1, 2: begin
          rx_mode = RX_FLOW;
          rx_left = $urandom_range(20, 600);
        end
        3, 4: begin
          rx_mode = RX_CHOPPY;
          rx_left = $urandom_range(20, 300);
        end
        default: begin
          rx_mode = RX_HOLD;
          rx_left = $urandom_range(1, 300);
        end
      endcase
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:   verdict_if.ready <= 1'b1;
      RX_CHOPPY: verdict_if.ready <= 1'($urandom_range(1));
      default:   verdict_if.ready <= 1'b0;
    endcase
  end

  // compare each verdict transfer with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict with none expected", verdict_if.heuristic_value, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_if.prune_flag !== want.prune_flag)
          report_mismatch("prune_flag", verdict_if.prune_flag, want.prune_flag);
        if (verdict_if.heuristic_value !== want.heuristic_value)
          report_mismatch("heuristic_value", verdict_if.heuristic_value, want.heuristic_value);
        if (verdict_if.table_changed !== want.table_changed)
          report_mismatch("table_changed", verdict_if.table_changed, want.table_changed);
        if (verdict_if.table_overflow !== want.table_overflow)
          report_mismatch("table_overflow", verdict_if.table_overflow, want.table_overflow);
      end
      verdicts_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               expected_verdicts.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [COST_W-1:0] cost;
    logic [MASK_W-1:0] reach;
    logic [MASK_W-1:0] sat;
    logic [MASK_W-1:0] hard;
    logic              prune;
    logic [COST_W-1:0] limit;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_HARD_GOAL;
    cfg_wdata               = '0;
    state_if.valid          = 1'b0;
    state_if.path_cost      = '0;
    state_if.reachable_mask = '0;
    state_if.satisfied_mask = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset settings
    for (int i = 0; i < PROBE_COUNT; i++)
      send_state(PROBE_ROWS[i].cost, PROBE_ROWS[i].reach, PROBE_ROWS[i].sat,
                 PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
    settle();

    // random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      hard        = '0;
      prune       = 1'b1;
      limit       = COST_LIMIT_RST;
      ph_wlo      = 4;
      ph_whi      = 16;
      ph_fill     = 1'b0;
      ph_sat_hard = 1'b1;
      case (p)
        1: begin
          hard   = 32'h1 << $urandom_range(MASK_W-1);
          limit  = COST_W'($urandom);
          ph_wlo = 6;
          ph_whi = 18;
        end
        2: begin
          hard   = weighted_mask(3);
          prune  = 1'b0;
          ph_wlo = 2;
          ph_whi = 12;
        end
        3: begin
          limit   = '0;
          ph_fill = 1'b1;
        end
        4: begin
          hard   = 32'h8000_0001;
          limit  = COST_W'($urandom_range(0, 1000));
          ph_whi = 14;
        end
        5: begin
          prune  = 1'b0;
          limit  = COST_W'($urandom);
          ph_wlo = 1;
          ph_whi = 20;
        end
        6: begin
          hard   = weighted_mask(2);
          ph_wlo = 2;
          ph_whi = 8;
        end
        7: begin
          hard        = ALL_GOALS;
          limit       = COST_W'($urandom);
          ph_wlo      = 8;
          ph_whi      = 20;
          ph_sat_hard = 1'b0;
        end
        default: ;
      endcase
      if (p > 0) begin
        write_reg(CFG_HARD_GOAL, hard);
        write_reg(CFG_PRUNE_EN, {{(CFG_DATA_W-1){1'b0}}, prune});
        write_reg(CFG_COST_LIMIT, {1'b0, limit});
      end
      if (p == 2 || p == 5) write_reg(CFG_UNUSED, $urandom);
      repeat (RANDOM_ITEMS / PHASES) begin
        pick_state(cost, reach, sat);
        send_state(cost, reach, sat, 1'b0, NO_TYPED);
      end
      // the full mask covers everything, so it only comes at the very end
      if (p == PHASES-1) begin
        send_state(31'h0000_0000, ALL_GOALS, ALL_GOALS, 1'b0, NO_TYPED);
        send_state(31'h7FFF_FFFF, $urandom, $urandom, 1'b0, NO_TYPED);
      end
      settle();
    end

    repeat (2*ITEM_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
